### rtl/core/sfdc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the frame deframer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sfdc_pkg;

   // Field widths of the result beat
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int ADDR_W   = 48;
   localparam int TYPE_W   = 16;
   localparam int CRC_W    = 32;
   localparam int LEN_W    = 11;

   // Frame layout (byte indexes within the frame)
   localparam int IDX_PREAMBLE   = 0;
   localparam int IDX_START      = 1;
   localparam int IDX_SRC_FIRST  = 8;
   localparam int IDX_TYPE_FIRST = 14;
   localparam int IDX_HDR_END    = 16;
   localparam int IDX_CRC_FIRST  = 6;    // first byte that pops out of the delay line
   localparam int IDX_PAY_FIRST  = 20;   // first byte whose popped byte is payload
   localparam int MIN_FRAME      = 20;

   // CRC-32, reflected
   localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

   // Register map (selected by address bit 2)
   localparam int  CSR_ADDR_W      = 3;
   localparam int  CSR_DATA_W      = 32;
   localparam logic CSR_SEL_PREAMBLE = 1'b0;
   localparam logic CSR_SEL_START    = 1'b1;
   localparam logic [BYTE_W-1:0] RST_PREAMBLE = 8'h55;
   localparam logic [BYTE_W-1:0] RST_START    = 8'hD5;

   // Result queue
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] preamble;
      logic [BYTE_W-1:0] start;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                is_payload;
      logic                frame_done;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   dest_address;
      logic [ADDR_W-1:0]   source_address;
      logic [TYPE_W-1:0]   frame_type;
      logic [CRC_W-1:0]    received_check;
      logic [LEN_W-1:0]    payload_length;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;   // beats pushed this cycle, 0 to 2
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // One byte of reflected CRC-32
   function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sfdc_csr.sv
// Configuration registers (preamble and start delimiter) behind an APB-style port.
// Depends on sfdc_pkg.
`default_nettype none

module sfdc_csr
   import sfdc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [BYTE_W-1:0] pre_ff, pre_in;
   logic [BYTE_W-1:0] sfd_ff, sfd_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Decode the write on the access phase
   always_comb begin
      pre_in = pre_ff;
      sfd_in = sfd_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_SEL_PREAMBLE: pre_in = pwdata[BYTE_W-1:0];
            CSR_SEL_START:    sfd_in = pwdata[BYTE_W-1:0];
            default:          pre_in = pre_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= RST_PREAMBLE;
         sfd_ff <= RST_START;
      end else begin
         pre_ff <= pre_in;
         sfd_ff <= sfd_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         CSR_SEL_PREAMBLE: prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, pre_ff};
         CSR_SEL_START:    prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, sfd_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.preamble = pre_ff;
   assign cfg.start    = sfd_ff;

endmodule

`default_nettype wire

### rtl/core/sfdc_core.sv
// Per-byte frame state: header capture, 4-byte delay line, CRC-32 and status.
// Depends on sfdc_pkg; produces up to two result beats per accepted byte.
`default_nettype none

module sfdc_core
   import sfdc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              last_byte,
   input  wire cfg_type           cfg,
   output push_type               push
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SUM_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [3:0][BYTE_W-1:0] dl_ff, dl_in;
   logic [CRC_W-1:0]       crc_ff, crc_in;
   logic [ADDR_W-1:0]      dst_ff, dst_in;
   logic [ADDR_W-1:0]      src_ff, src_in;
   logic [TYPE_W-1:0]      typ_ff, typ_in;
   logic                   bad_ff, bad_in;
   logic                   ovf_ff, ovf_in;

   logic                   pay_vld;
   logic                   sta_vld;
   rsp_type                pay_rsp;
   rsp_type                sta_rsp;
   logic [SUM_W-1:0]       cnt_wide;
   logic [CRC_W-1:0]       calc_crc;

   // Advance the frame state for one byte and build its results
   always_comb begin
      cnt_in   = cnt_ff;
      dl_in    = dl_ff;
      crc_in   = crc_ff;
      dst_in   = dst_ff;
      src_in   = src_ff;
      typ_in   = typ_ff;
      bad_in   = bad_ff;
      ovf_in   = ovf_ff;
      pay_vld  = 1'b0;
      sta_vld  = 1'b0;
      pay_rsp  = '0;
      sta_rsp  = '0;
      cnt_wide = '0;
      calc_crc = '0;

      if (accept) begin
         if (cnt_ff >= MAX_CNT) begin
            // saturated: drop the byte, remember the overrun
            ovf_in = 1'b1;
         end else begin
            if (cnt_ff == CNT_W'(IDX_PREAMBLE)) begin
               if (data_byte != cfg.preamble) bad_in = 1'b1;
            end else if (cnt_ff == CNT_W'(IDX_START)) begin
               if (data_byte != cfg.start) bad_in = 1'b1;
            end else begin
               dl_in = {data_byte, dl_ff[3], dl_ff[2], dl_ff[1]};
               if (cnt_ff < CNT_W'(IDX_SRC_FIRST)) begin
                  dst_in = {dst_ff[ADDR_W-BYTE_W-1:0], data_byte};
               end else if (cnt_ff < CNT_W'(IDX_TYPE_FIRST)) begin
                  src_in = {src_ff[ADDR_W-BYTE_W-1:0], data_byte};
               end else if (cnt_ff < CNT_W'(IDX_HDR_END)) begin
                  typ_in = {typ_ff[TYPE_W-BYTE_W-1:0], data_byte};
               end
               if (cnt_ff >= CNT_W'(IDX_CRC_FIRST)) begin
                  crc_in = crc_fold_byte(crc_ff, dl_ff[0]);
                  if (cnt_ff >= CNT_W'(IDX_PAY_FIRST) && !bad_ff) begin
                     pay_vld            = 1'b1;
                     pay_rsp.out_byte   = dl_ff[0];
                     pay_rsp.is_payload = 1'b1;
                  end
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end

         // Close the frame on its last byte
         if (last_byte) begin
            sta_vld                = 1'b1;
            calc_crc               = crc_in ^ CRC_ALL_ONES;
            cnt_wide               = SUM_W'(cnt_in);
            sta_rsp.frame_done     = 1'b1;
            sta_rsp.dest_address   = dst_in;
            sta_rsp.source_address = src_in;
            sta_rsp.frame_type     = typ_in;
            sta_rsp.received_check = dl_in;
            if (cnt_wide < SUM_W'(MIN_FRAME)) begin
               sta_rsp.status         = ST_TOO_SHORT;
               sta_rsp.payload_length = '0;
            end else begin
               sta_rsp.payload_length = LEN_W'(cnt_wide - SUM_W'(MIN_FRAME));
               if (bad_in) begin
                  sta_rsp.status = ST_BAD_START;
               end else if (ovf_in) begin
                  sta_rsp.status = ST_TOO_LONG;
               end else if (dl_in != calc_crc) begin
                  sta_rsp.status = ST_CRC_BAD;
               end else begin
                  sta_rsp.status = ST_OK;
               end
            end
            cnt_in = '0;
            dl_in  = '0;
            crc_in = CRC_ALL_ONES;
            dst_in = '0;
            src_in = '0;
            typ_in = '0;
            bad_in = 1'b0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         dl_ff  <= '0;
         crc_ff <= CRC_ALL_ONES;
         dst_ff <= '0;
         src_ff <= '0;
         typ_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         dl_ff  <= dl_in;
         crc_ff <= crc_in;
         dst_ff <= dst_in;
         src_ff <= src_in;
         typ_ff <= typ_in;
         bad_ff <= bad_in;
         ovf_ff <= ovf_in;
      end
   end

   // Payload beat goes first, the status beat after it
   always_comb begin
      push.count  = {1'b0, pay_vld} + {1'b0, sta_vld};
      push.first  = pay_vld ? pay_rsp : sta_rsp;
      push.second = sta_rsp;
   end

endmodule

`default_nettype wire

### rtl/core/sfdc_rsp_fifo.sv
// Four-entry result queue: takes up to two beats a cycle, hands out one.
// Depends on sfdc_pkg.
`default_nettype none

module sfdc_rsp_fifo
   import sfdc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          has_room,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp
);

   rsp_type               mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wp_ff, wp_in;
   logic [RQ_PTR_W-1:0]   rp_ff, rp_in;
   logic [RQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  pop;
   logic [RQ_PTR_W-1:0]   wp_next;

   // Room for a full two-beat push
   assign has_room  = cnt_ff <= RQ_CNT_W'(RQ_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp       = mem_ff[rp_ff];
   assign pop       = rsp_valid & rsp_ready;
   assign wp_next   = wp_ff + RQ_PTR_W'(1);

   // Advance pointers and fill level
   always_comb begin
      wp_in  = wp_ff + RQ_PTR_W'(push.count);
      rp_in  = pop ? rp_ff + RQ_PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed beats
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

### rtl/core/serial_frame_deframer_crc32_unit.sv
// Top level of the serial frame deframer with CRC-32 check.
// Depends on sfdc_pkg, sfdc_csr, sfdc_core and sfdc_rsp_fifo.
//
//   channel   ports                       beat
//   --------  --------------------------  ------------------------------------
//   request   req_valid / req_ready       one frame byte plus last-byte flag
//   response  rsp_valid / rsp_ready       payload byte or closing frame status
//   config    psel penable pwrite paddr   preamble (addr 0), start byte (addr 4)
//
// A byte is taken every cycle while the result queue has room for two beats;
// its state update and result beats are formed in the cycle it is taken, and
// results are registered into a four-entry queue that hands them out.
// Throughput is one byte a cycle while responses are taken, bounded also by the
// one-beat-per-cycle port when a last byte yields a payload and a status beat.
// Reset is synchronous; it clears the frame state and the queue and loads the
// default preamble and start byte. Response stalls back up into req_ready.
`default_nettype none

module serial_frame_deframer_crc32_unit
   import sfdc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_last_byte,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [BYTE_W-1:0]          rsp_out_byte,
   output logic                       rsp_is_payload,
   output logic                       rsp_frame_done,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ADDR_W-1:0]          rsp_dest_address,
   output logic [ADDR_W-1:0]          rsp_source_address,
   output logic [TYPE_W-1:0]          rsp_frame_type,
   output logic [CRC_W-1:0]           rsp_received_check,
   output logic [LEN_W-1:0]           rsp_payload_length,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   cfg_type  cfg;
   push_type push;
   rsp_type  rsp;
   logic     has_room;
   logic     accept;

   assign req_ready = has_room;
   assign accept    = req_valid & has_room;

   sfdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfdc_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg),
      .push      (push)
   );

   sfdc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Break the result beat out onto its ports
   assign rsp_out_byte       = rsp.out_byte;
   assign rsp_is_payload     = rsp.is_payload;
   assign rsp_frame_done     = rsp.frame_done;
   assign rsp_status         = rsp.status;
   assign rsp_dest_address   = rsp.dest_address;
   assign rsp_source_address = rsp.source_address;
   assign rsp_frame_type     = rsp.frame_type;
   assign rsp_received_check = rsp.received_check;
   assign rsp_payload_length = rsp.payload_length;

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for serial_frame_deframer_crc32_unit: frame bytes in, payload and
// status beats out, each checked against an in-bench model of the deframer.
// Depends on sfdc_pkg and the RTL of the block; nothing else.
`default_nettype none

module tb;
   import sfdc_pkg::*;

   localparam int FRAME_LIMIT = 2048;
   localparam int IDLE_LIMIT  = 5000;
   localparam int SETTLE      = 10;
   localparam int PHASE_BYTES = 460;

   typedef enum int {
      REG_PREAMBLE    = 0,
      REG_START_DELIM = 1
   } csr_index_type;

   typedef enum int {
      FR_GOOD,
      FR_CRC_BAD,
      FR_START_BAD,
      FR_SHORT,
      FR_NOISE
   } frame_kind_type;

   // Model of the deframer plus the queue of beats it still owes
   class frame_outcome_tracker;
      rsp_type          pending_beats[$];
      int unsigned      errors;
      logic [7:0]       preamble_cfg;
      logic [7:0]       start_cfg;
      int unsigned      max_bytes;
      int unsigned      byte_count;
      logic [7:0]       delay_line[4];
      logic [31:0]      crc_acc;
      logic [47:0]      dest_acc;
      logic [47:0]      source_acc;
      logic [15:0]      type_acc;
      bit               start_bad;
      bit               overflow;

      function new(int unsigned limit);
         max_bytes    = limit;
         errors       = 0;
         preamble_cfg = 8'h55;
         start_cfg    = 8'hD5;
         clear_frame();
      endfunction

      static function logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
         logic [31:0] c;
         c = crc ^ {24'h0, b};
         for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ 32'hEDB8_8320;
            else c = c >> 1;
         end
         return c;
      endfunction

      function void clear_frame();
         byte_count = 0;
         foreach (delay_line[k]) delay_line[k] = 8'h00;
         crc_acc    = 32'hFFFF_FFFF;
         dest_acc   = '0;
         source_acc = '0;
         type_acc   = '0;
         start_bad  = 0;
         overflow   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] val);
         if (idx == REG_PREAMBLE) preamble_cfg = val;
         else start_cfg = val;
      endfunction

      function int pending();
         return pending_beats.size();
      endfunction

      // Advance the model by one accepted byte and queue the beats it causes
      function void take_byte(logic [7:0] b, logic last);
         rsp_type     beat;
         logic [7:0]  popped;
         logic [31:0] trailer;
         if (byte_count >= max_bytes) begin
            overflow = 1;
         end else begin
            if (byte_count == IDX_PREAMBLE) begin
               if (b != preamble_cfg) start_bad = 1;
            end else if (byte_count == IDX_START) begin
               if (b != start_cfg) start_bad = 1;
            end else begin
               popped        = delay_line[0];
               delay_line[0] = delay_line[1];
               delay_line[1] = delay_line[2];
               delay_line[2] = delay_line[3];
               delay_line[3] = b;
               if (byte_count < IDX_SRC_FIRST) dest_acc = {dest_acc[39:0], b};
               else if (byte_count < IDX_TYPE_FIRST) source_acc = {source_acc[39:0], b};
               else if (byte_count < IDX_HDR_END) type_acc = {type_acc[7:0], b};
               if (byte_count >= IDX_CRC_FIRST) begin
                  crc_acc = crc_byte(crc_acc, popped);
                  if (byte_count >= IDX_PAY_FIRST && !start_bad) begin
                     beat            = '0;
                     beat.out_byte   = popped;
                     beat.is_payload = 1'b1;
                     pending_beats.push_back(beat);
                  end
               end
            end
            byte_count++;
         end

         // Close the frame with its status beat
         if (last) begin
            trailer = {delay_line[3], delay_line[2], delay_line[1], delay_line[0]};
            beat                = '0;
            beat.frame_done     = 1'b1;
            beat.dest_address   = dest_acc;
            beat.source_address = source_acc;
            beat.frame_type     = type_acc;
            beat.received_check = trailer;
            if (byte_count < MIN_FRAME) beat.status = ST_TOO_SHORT;
            else if (start_bad) beat.status = ST_BAD_START;
            else if (overflow) beat.status = ST_TOO_LONG;
            else if (trailer != (crc_acc ^ 32'hFFFF_FFFF)) beat.status = ST_CRC_BAD;
            else beat.status = ST_OK;
            if (byte_count >= MIN_FRAME) beat.payload_length = LEN_W'(byte_count - MIN_FRAME);
            pending_beats.push_back(beat);
            clear_frame();
         end
      endfunction

      function void compare_field(string name, logic [63:0] expv, logic [63:0] gotv);
         if (expv !== gotv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, gotv);
            errors++;
         end
      endfunction

      // Check one received beat against the oldest owed beat
      function void match_beat(rsp_type got);
         rsp_type want;
         if (pending_beats.size() == 0) begin
            $error("response beat with nothing expected: 0x%0h", got);
            errors++;
         end else begin
            want = pending_beats.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("is_payload", want.is_payload, got.is_payload);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("status", want.status, got.status);
            compare_field("dest_address", want.dest_address, got.dest_address);
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("received_check", want.received_check, got.received_check);
            compare_field("payload_length", want.payload_length, got.payload_length);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_is_payload;
   logic                  rsp_frame_done;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_dest_address;
   logic [ADDR_W-1:0]     rsp_source_address;
   logic [TYPE_W-1:0]     rsp_frame_type;
   logic [CRC_W-1:0]      rsp_received_check;
   logic [LEN_W-1:0]      rsp_payload_length;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   frame_outcome_tracker tracker = new(FRAME_LIMIT);
   logic [7:0]           frame_buf[$];
   int unsigned          bytes_sent = 0;
   int unsigned          idle_cycles = 0;
   int                   req_gap_pct = 0;
   int                   rsp_stall_pct = 0;

   serial_frame_deframer_crc32_unit #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_payload     (rsp_is_payload),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_status         (rsp_status),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_address (rsp_source_address),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_received_check (rsp_received_check),
      .rsp_payload_length (rsp_payload_length),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Randomly stall the response side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.match_beat('{rsp_out_byte, rsp_is_payload, rsp_frame_done, rsp_status,
                              rsp_dest_address, rsp_source_address, rsp_frame_type,
                              rsp_received_check, rsp_payload_length});
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one byte, hold it until accepted, then feed it to the model
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
   endtask

   // Build a well-formed frame: header, random payload, little-endian trailer
   task automatic build_good_frame(input int body_len);
      logic [31:0] crc;
      frame_buf.delete();
      frame_buf.push_back(tracker.preamble_cfg);
      frame_buf.push_back(tracker.start_cfg);
      repeat (14 + body_len) frame_buf.push_back(8'($urandom_range(255)));
      crc = 32'hFFFF_FFFF;
      for (int k = 2; k < frame_buf.size(); k++) begin
         crc = frame_outcome_tracker::crc_byte(crc, frame_buf[k]);
      end
      crc = crc ^ 32'hFFFF_FFFF;
      for (int k = 0; k < 4; k++) frame_buf.push_back(crc[8*k +: 8]);
   endtask

   task automatic build_frame(input frame_kind_type kind, input int body_len);
      int len;
      build_good_frame(body_len);
      case (kind)
         FR_CRC_BAD: begin
            frame_buf[$urandom_range(frame_buf.size() - 1, 2)] ^= 8'(1 << $urandom_range(7));
         end
         FR_START_BAD: begin
            frame_buf[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
         end
         FR_SHORT: begin
            len = $urandom_range(MIN_FRAME - 1, 1);
            while (frame_buf.size() > len) void'(frame_buf.pop_back());
         end
         FR_NOISE: begin
            len = $urandom_range(60, 1);
            frame_buf.delete();
            repeat (len) frame_buf.push_back(8'($urandom_range(255)));
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise
   task automatic random_frames(input int unsigned target);
      int unsigned    first;
      int             pick;
      int             plen;
      frame_kind_type kind;
      first = bytes_sent;
      while (bytes_sent - first < target) begin
         pick = $urandom_range(99);
         if (pick < 60) kind = FR_GOOD;
         else if (pick < 70) kind = FR_CRC_BAD;
         else if (pick < 80) kind = FR_START_BAD;
         else if (pick < 90) kind = FR_SHORT;
         else kind = FR_NOISE;
         plen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(40);
         build_frame(kind, plen);
         send_frame();
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= {24'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_register(idx, val);
   endtask

   // Release valid, wait for every owed beat, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sender idles rarely, receiver often
      req_gap_pct   = 8;
      rsp_stall_pct = 45;

      // Directed: smallest good frame, short frames, bad start bytes, bad crc
      build_frame(FR_GOOD, 0);
      send_frame();
      frame_buf = '{8'h55};
      send_frame();
      build_frame(FR_SHORT, 0);
      send_frame();
      build_good_frame(0);
      frame_buf[IDX_PREAMBLE] = 8'hFF;
      send_frame();
      build_good_frame(0);
      frame_buf[IDX_START] = 8'h00;
      send_frame();
      build_frame(FR_CRC_BAD, 1);
      send_frame();
      random_frames(PHASE_BYTES);
      drain();

      // Extreme register values, receiver idles rarely, sender often
      csr_write(REG_PREAMBLE, 8'h00);
      csr_write(REG_START_DELIM, 8'hFF);
      req_gap_pct   = 45;
      rsp_stall_pct = 8;
      random_frames(PHASE_BYTES);
      drain();

      // Opposite extremes, no idling
      csr_write(REG_PREAMBLE, 8'hFF);
      csr_write(REG_START_DELIM, 8'h00);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      random_frames(PHASE_BYTES);
      drain();

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/sfdc_pkg.sv
rtl/core/sfdc_csr.sv
rtl/core/sfdc_core.sv
rtl/core/sfdc_rsp_fifo.sv
rtl/core/serial_frame_deframer_crc32_unit.sv
test/tb.sv
